[rtl/core/multilist_index_insert_macros.svh]
// Assertion macros for the multilist index table RTL.
`ifndef MULTILIST_INDEX_INSERT_MACROS_SVH
`define MULTILIST_INDEX_INSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mli_pkg.sv]
package mli_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;

  localparam int STUDENT_KEY_W = 48;
  localparam int COURSE_HIGH_W = 8;
  localparam int COURSE_LOW_W  = 64;
  localparam int INDEX_OUT_W   = 4;
  localparam int LINK_OUT_W    = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_UNFILLED = 2'd2;

  // Two's complement -1 on a link output
  localparam logic [LINK_OUT_W-1:0] LINK_OUT_NONE = '1;

  typedef struct packed {
    logic [STUDENT_KEY_W-1:0] student;
    logic [COURSE_HIGH_W-1:0] course_high;
    logic [COURSE_LOW_W-1:0]  course_low;
  } key_word_t;

  typedef struct packed {
    logic student_eq;
    logic course_eq;
  } key_match_t;

endpackage

[rtl/core/mli_key_store.sv]
module mli_key_store #(
  parameter int DEPTH = mli_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                         clk,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  mli_pkg::key_word_t           wr_data,
  input  mli_pkg::key_word_t           cmp_key,
  output mli_pkg::key_word_t           rd_data,
  output mli_pkg::key_match_t          match
);
  import mli_pkg::*;

  key_word_t mem [DEPTH];
  key_word_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_data = rd_q_r;

  // compare the entry read last cycle against the key being inserted
  assign match.student_eq = (rd_q_r.student == cmp_key.student);
  assign match.course_eq  = (rd_q_r.course_high == cmp_key.course_high) &&
                            (rd_q_r.course_low == cmp_key.course_low);

endmodule

[rtl/core/mli_link_store.sv]
module mli_link_store #(
  parameter int DEPTH = mli_pkg::DEF_TABLE_ENTRIES,
  parameter int WIDTH = 4 * ($clog2(mli_pkg::DEF_TABLE_ENTRIES) + 1)
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);
  import mli_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_data = rd_q_r;

endmodule

[rtl/core/multilist_index_insert.sv]
// Enrolment index table: up to TABLE_ENTRIES entries, each on a student chain and a course
// chain. Raise start with a command while busy is low; the result appears on the out_ ports
// for exactly one cycle with out_valid high and cannot be held off, so capture it then.
// A read of an unfilled entry and an insert into a full table are answered from the idle state;
// a read of a filled entry passes through the read state first. An insert into a table holding
// n entries does one key-store read per stored entry for the first-match scan, link-store
// reads to walk the matching student and course chains to their tails (none when the key is new),
// and one to three link-store writes for the new entry and the two tail updates. Both stores
// have one read and one write port and a registered read.
`include "multilist_index_insert_macros.svh"

module multilist_index_insert #(
  parameter int TABLE_ENTRIES = mli_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_command,
  input  logic [3:0]                             in_entry_select,
  input  logic [mli_pkg::STUDENT_KEY_W-1:0]      in_student_key,
  input  logic [mli_pkg::COURSE_HIGH_W-1:0]      in_course_key_high,
  input  logic [mli_pkg::COURSE_LOW_W-1:0]       in_course_key_low,
  output logic                                   out_valid,
  output logic [1:0]                             out_status,
  output logic [mli_pkg::INDEX_OUT_W-1:0]        out_entry_index,
  output logic                                   out_student_is_new,
  output logic                                   out_course_is_new,
  output logic signed [mli_pkg::LINK_OUT_W-1:0]  out_student_back,
  output logic signed [mli_pkg::LINK_OUT_W-1:0]  out_course_back,
  output logic signed [mli_pkg::LINK_OUT_W-1:0]  out_student_forward,
  output logic signed [mli_pkg::LINK_OUT_W-1:0]  out_course_forward,
  output logic [mli_pkg::STUDENT_KEY_W-1:0]      out_student_key_read,
  output logic [mli_pkg::COURSE_HIGH_W-1:0]      out_course_key_high_read,
  output logic [mli_pkg::COURSE_LOW_W-1:0]       out_course_key_low_read
);
  import mli_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // A link is a valid flag and an entry index; an invalid link means "none"
  typedef struct packed {
    logic             v;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    link_t s_next;
    link_t s_prev;
    link_t c_next;
    link_t c_prev;
  } link_word_t;

  localparam int LINK_W = $bits(link_word_t);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_SWALK = 3'd3;
  localparam logic [2:0] ST_CWALK = 3'd4;
  localparam logic [2:0] ST_WNEW  = 3'd5;
  localparam logic [2:0] ST_WSTU  = 3'd6;
  localparam logic [2:0] ST_WCRS  = 3'd7;

  localparam link_t LINK_NONE = '{v: 1'b0, idx: '0};

  // Entry index reported modulo the 4-bit output field
  function automatic logic [INDEX_OUT_W-1:0] idx_out(input logic [IDX_W-1:0] i);
    logic [IDX_W+INDEX_OUT_W-1:0] e;
    e = (IDX_W + INDEX_OUT_W)'(i);
    return e[INDEX_OUT_W-1:0];
  endfunction

  // Link reported modulo the 5-bit output field, none as -1
  function automatic logic [LINK_OUT_W-1:0] link_out(input link_t l);
    logic [IDX_W+LINK_OUT_W-1:0] e;
    e = (IDX_W + LINK_OUT_W)'(l.idx);
    return l.v ? e[LINK_OUT_W-1:0] : LINK_OUT_NONE;
  endfunction

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  key_word_t        key_r, key_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0] cur_r;
  link_t            sfirst_r, sfirst_nxt;
  link_t            cfirst_r, cfirst_nxt;
  link_t            sback_r, sback_nxt;
  link_t            cback_r, cback_nxt;
  link_word_t       sword_r, sword_nxt;
  link_word_t       cword_r, cword_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [INDEX_OUT_W-1:0] out_index_r, out_index_nxt;
  logic                  out_snew_r, out_snew_nxt;
  logic                  out_cnew_r, out_cnew_nxt;
  logic [LINK_OUT_W-1:0] out_sback_r, out_sback_nxt;
  logic [LINK_OUT_W-1:0] out_cback_r, out_cback_nxt;
  logic [LINK_OUT_W-1:0] out_sfwd_r, out_sfwd_nxt;
  logic [LINK_OUT_W-1:0] out_cfwd_r, out_cfwd_nxt;
  key_word_t             out_key_r, out_key_nxt;

  logic                  accept;
  logic                  finish;
  logic [IDX_W-1:0]      n_idx;
  logic [IDX_W+3:0]      sel_wide;
  logic [IDX_W-1:0]      sel_idx;
  logic                  sel_unfilled;
  logic                  scan_last;
  link_t                 s_hit;
  link_t                 c_hit;
  link_t                 new_link;

  key_word_t             key_in;
  logic [IDX_W-1:0]      key_raddr;
  logic                  key_we;
  key_word_t             key_rdata;
  key_match_t            key_match;

  logic [IDX_W-1:0]      link_raddr;
  logic                  link_we;
  logic [IDX_W-1:0]      link_waddr;
  link_word_t            link_wdata;
  link_word_t            link_rdata;
  logic [LINK_W-1:0]     link_rdata_bits;

  mli_key_store #(
    .DEPTH (TABLE_ENTRIES)
  ) u_key_store (
    .clk     (clk),
    .rd_addr (key_raddr),
    .wr_en   (key_we),
    .wr_addr (n_idx),
    .wr_data (key_r),
    .cmp_key (key_r),
    .rd_data (key_rdata),
    .match   (key_match)
  );

  mli_link_store #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (LINK_W)
  ) u_link_store (
    .clk     (clk),
    .rd_addr (link_raddr),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_data (link_rdata_bits)
  );

  assign link_rdata = link_word_t'(link_rdata_bits);

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign key_in.student     = in_student_key;
  assign key_in.course_high = in_course_key_high;
  assign key_in.course_low  = in_course_key_low;

  // New entry always goes to the first free slot
  assign n_idx    = count_r[IDX_W-1:0];
  assign new_link = '{v: 1'b1, idx: n_idx};

  assign sel_wide     = (IDX_W + 4)'(in_entry_select);
  assign sel_idx      = sel_wide[IDX_W-1:0];
  assign sel_unfilled = ((CNT_W + 4)'(in_entry_select) >= (CNT_W + 4)'(count_r));

  assign scan_last = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);

  // First match so far, including the entry compared this cycle
  assign s_hit = sfirst_r.v ? sfirst_r :
                 (key_match.student_eq ? link_t'{v: 1'b1, idx: scan_idx_r} : LINK_NONE);
  assign c_hit = cfirst_r.v ? cfirst_r :
                 (key_match.course_eq ? link_t'{v: 1'b1, idx: scan_idx_r} : LINK_NONE);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    key_nxt      = key_r;
    scan_idx_nxt = scan_idx_r;
    sfirst_nxt   = sfirst_r;
    cfirst_nxt   = cfirst_r;
    sback_nxt    = sback_r;
    cback_nxt    = cback_r;
    sword_nxt    = sword_r;
    cword_nxt    = cword_r;
    finish       = 1'b0;

    // Scan reads the next entry by default; walks re-read the current one
    key_raddr  = IDX_W'(scan_idx_r + 1'b1);
    link_raddr = cur_r;
    key_we     = 1'b0;
    link_we    = 1'b0;
    link_waddr = n_idx;
    link_wdata = '{s_next: LINK_NONE, s_prev: sback_r, c_next: LINK_NONE, c_prev: cback_r};

    out_valid_nxt  = 1'b0;
    out_status_nxt = STATUS_OK;
    out_index_nxt  = '0;
    out_snew_nxt   = 1'b0;
    out_cnew_nxt   = 1'b0;
    out_sback_nxt  = LINK_OUT_NONE;
    out_cback_nxt  = LINK_OUT_NONE;
    out_sfwd_nxt   = LINK_OUT_NONE;
    out_cfwd_nxt   = LINK_OUT_NONE;
    out_key_nxt    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt    = key_in;
          sfirst_nxt = LINK_NONE;
          cfirst_nxt = LINK_NONE;
          sback_nxt  = LINK_NONE;
          cback_nxt  = LINK_NONE;
          if (in_command == CMD_READ) begin
            if (sel_unfilled) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_UNFILLED;
              out_index_nxt  = in_entry_select;
            end else begin
              key_raddr  = sel_idx;
              link_raddr = sel_idx;
              state_nxt  = ST_READ;
            end
          end else if (count_r == CNT_W'(TABLE_ENTRIES)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_FULL;
          end else if (count_r == '0) begin
            state_nxt = ST_WNEW;
          end else begin
            key_raddr    = '0;
            scan_idx_nxt = '0;
            state_nxt    = ST_SCAN;
          end
        end
      end

      ST_READ: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STATUS_OK;
        out_index_nxt  = idx_out(cur_r);
        out_sback_nxt  = link_out(link_rdata.s_prev);
        out_cback_nxt  = link_out(link_rdata.c_prev);
        out_sfwd_nxt   = link_out(link_rdata.s_next);
        out_cfwd_nxt   = link_out(link_rdata.c_next);
        out_key_nxt    = key_rdata;
        state_nxt      = ST_IDLE;
      end

      ST_SCAN: begin
        sfirst_nxt = s_hit;
        cfirst_nxt = c_hit;
        if (scan_last) begin
          if (s_hit.v) begin
            link_raddr = s_hit.idx;
            state_nxt  = ST_SWALK;
          end else if (c_hit.v) begin
            link_raddr = c_hit.idx;
            state_nxt  = ST_CWALK;
          end else begin
            state_nxt = ST_WNEW;
          end
        end else begin
          scan_idx_nxt = IDX_W'(scan_idx_r + 1'b1);
        end
      end

      ST_SWALK: begin
        if (link_rdata.s_next.v) begin
          link_raddr = link_rdata.s_next.idx;
        end else begin
          sback_nxt = '{v: 1'b1, idx: cur_r};
          sword_nxt = link_rdata;
          if (cfirst_r.v) begin
            link_raddr = cfirst_r.idx;
            state_nxt  = ST_CWALK;
          end else begin
            state_nxt = ST_WNEW;
          end
        end
      end

      ST_CWALK: begin
        if (link_rdata.c_next.v) begin
          link_raddr = link_rdata.c_next.idx;
        end else begin
          cback_nxt = '{v: 1'b1, idx: cur_r};
          cword_nxt = link_rdata;
          state_nxt = ST_WNEW;
        end
      end

      ST_WNEW: begin
        key_we  = 1'b1;
        link_we = 1'b1;
        if (sback_r.v) begin
          state_nxt = ST_WSTU;
        end else if (cback_r.v) begin
          state_nxt = ST_WCRS;
        end else begin
          finish = 1'b1;
        end
      end

      ST_WSTU: begin
        link_we           = 1'b1;
        link_waddr        = sback_r.idx;
        link_wdata        = sword_r;
        link_wdata.s_next = new_link;
        if (cback_r.v) begin
          state_nxt = ST_WCRS;
        end else begin
          finish = 1'b1;
        end
      end

      ST_WCRS: begin
        link_we           = 1'b1;
        link_waddr        = cback_r.idx;
        link_wdata        = cword_r;
        link_wdata.c_next = new_link;
        // Same tail on both chains: keep the student update written just before
        if (sback_r.v && (sback_r.idx == cback_r.idx)) begin
          link_wdata.s_next = new_link;
        end
        finish = 1'b1;
      end
    endcase

    if (finish) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STATUS_OK;
      out_index_nxt  = idx_out(n_idx);
      out_snew_nxt   = !sfirst_r.v;
      out_cnew_nxt   = !cfirst_r.v;
      out_sback_nxt  = link_out(sback_r);
      out_cback_nxt  = link_out(cback_r);
      out_key_nxt    = key_r;
      count_nxt      = CNT_W'(count_r + 1'b1);
      state_nxt      = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers: no reset needed
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    scan_idx_r <= scan_idx_nxt;
    cur_r      <= link_raddr;
    sfirst_r   <= sfirst_nxt;
    cfirst_r   <= cfirst_nxt;
    sback_r    <= sback_nxt;
    cback_r    <= cback_nxt;
    sword_r    <= sword_nxt;
    cword_r    <= cword_nxt;
    if (out_valid_nxt) begin
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
      out_snew_r   <= out_snew_nxt;
      out_cnew_r   <= out_cnew_nxt;
      out_sback_r  <= out_sback_nxt;
      out_cback_r  <= out_cback_nxt;
      out_sfwd_r   <= out_sfwd_nxt;
      out_cfwd_r   <= out_cfwd_nxt;
      out_key_r    <= out_key_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_status               = out_status_r;
  assign out_entry_index          = out_index_r;
  assign out_student_is_new       = out_snew_r;
  assign out_course_is_new        = out_cnew_r;
  assign out_student_back         = out_sback_r;
  assign out_course_back          = out_cback_r;
  assign out_student_forward      = out_sfwd_r;
  assign out_course_forward       = out_cfwd_r;
  assign out_student_key_read     = out_key_r.student;
  assign out_course_key_high_read = out_key_r.course_high;
  assign out_course_key_low_read  = out_key_r.course_low;

  `MLI_ASSERT_NXT(a_accept_progress, accept, busy || out_valid_r, "accepted command lost")
  `MLI_ASSERT_IMP(a_full_count, out_valid_r && (out_status_r == STATUS_FULL), count_r == CNT_W'(TABLE_ENTRIES), "full reported below capacity")
  `MLI_ASSERT_IMP(a_scan_range, state_r == ST_SCAN, CNT_W'(scan_idx_r) < count_r, "scan beyond filled entries")
  `MLI_ASSERT_IMP(a_tail_stored, state_r == ST_WSTU, sback_r.v && (CNT_W'(sback_r.idx) < count_r), "student tail not a stored entry")
  `MLI_ASSERT_NXT(a_last_write_done, state_r == ST_WCRS, (state_r == ST_IDLE) && out_valid_r, "insert result not issued after write-back")

endmodule
